>>> hw/rtl/sorted_key_accumulate_table_macros.svh
// ----------------------------------------------------------------------------
// sorted_key_accumulate_table_macros
// Assertion shorthands shared by the table RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_ACCUMULATE_TABLE_MACROS_SVH
`define SORTED_KEY_ACCUMULATE_TABLE_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define SKAT_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// Same-cycle implication.
`define SKAT_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SKAT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/skat_pkg.sv
// ----------------------------------------------------------------------------
// skat_pkg
// Shared widths, cell opcodes, controller states and cell control bundle.
// ----------------------------------------------------------------------------
package skat_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 32;
    localparam int CODE_W              = 16;
    localparam int AMT_W               = 16;
    localparam int TOTAL_W             = 32;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CMP,
        CELL_UPD,
        CELL_ROT
    } cell_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD,
        ST_FIN,
        ST_DUMP
    } state_t;

    typedef struct packed {
        cell_op_t           op;
        logic [CODE_W-1:0]  code;
        logic [AMT_W-1:0]   amount;
        logic               any_eq;
        logic               drop;
    } cell_ctrl_t;

endpackage

>>> hw/rtl/skat_cell.sv
// ----------------------------------------------------------------------------
// skat_cell
// One table slot: key, total, occupancy and the compare flags of the request.
// ----------------------------------------------------------------------------
module skat_cell (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  skat_pkg::cell_ctrl_t              ctrl,
    input  logic                              prev_lt,
    input  logic                              prev_valid,
    input  logic [skat_pkg::CODE_W-1:0]       prev_code,
    input  logic [skat_pkg::TOTAL_W-1:0]      prev_total,
    input  logic                              next_valid,
    input  logic [skat_pkg::CODE_W-1:0]       next_code,
    input  logic [skat_pkg::TOTAL_W-1:0]      next_total,
    output logic                              valid,
    output logic [skat_pkg::CODE_W-1:0]       code,
    output logic [skat_pkg::TOTAL_W-1:0]      total,
    output logic                              lt,
    output logic                              eq,
    output logic [skat_pkg::TOTAL_W-1:0]      sum
);

    logic                           valid_reg, valid_next;
    logic                           lt_reg, lt_next;
    logic                           eq_reg, eq_next;
    logic [skat_pkg::CODE_W-1:0]    key_reg, key_next;
    logic [skat_pkg::TOTAL_W-1:0]   total_reg, total_next;
    logic [skat_pkg::TOTAL_W:0]     sum_wide;

    // saturating accumulate
    assign sum_wide = {1'b0, total_reg} + (skat_pkg::TOTAL_W+1)'(ctrl.amount);
    assign sum      = sum_wide[skat_pkg::TOTAL_W] ? '1 : sum_wide[skat_pkg::TOTAL_W-1:0];

    always_comb begin
        valid_next = valid_reg;
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        key_next   = key_reg;
        total_next = total_reg;
        case (ctrl.op)
            skat_pkg::CELL_CMP: begin
                lt_next = valid_reg && (key_reg < ctrl.code);
                eq_next = valid_reg && (key_reg == ctrl.code);
            end
            skat_pkg::CELL_UPD: begin
                if (!ctrl.drop) begin
                    if (ctrl.any_eq) begin
                        if (eq_reg) begin
                            total_next = sum;
                        end
                    end else if (!lt_reg) begin
                        if (prev_lt) begin
                            // insertion point
                            valid_next = 1'b1;
                            key_next   = ctrl.code;
                            total_next = {{(skat_pkg::TOTAL_W-skat_pkg::AMT_W){1'b0}},
                                          ctrl.amount};
                        end else begin
                            valid_next = prev_valid;
                            key_next   = prev_code;
                            total_next = prev_total;
                        end
                    end
                end
            end
            skat_pkg::CELL_ROT: begin
                valid_next = next_valid;
                key_next   = next_code;
                total_next = next_total;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            lt_reg    <= lt_next;
            eq_reg    <= eq_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        total_reg <= total_next;
    end

    assign valid = valid_reg;
    assign code  = key_reg;
    assign total = total_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

>>> hw/rtl/sorted_key_accumulate_table.sv
// ----------------------------------------------------------------------------
// sorted_key_accumulate_table
// Sorted key/total table with saturating accumulate, running maximum and dump.
// ----------------------------------------------------------------------------
// Holds up to TABLE_DEPTH entries in a row of cells kept in ascending key
// order, occupied cells packed from cell 0. An add request passes through
// these steps before the next is accepted: taking the request, a compare of
// every cell's key against the request key, an update in which the cells
// either accumulate into the matching entry or shift up by one to open the
// insertion slot, and a finish that updates the running maximum and loads
// the result register. A dump request rotates the whole row through cell 0
// once, one step per cycle, and emits one result per occupied cell, or one
// blank result for an empty table; a step waits while the result register
// is still held. The result register lets the next request be accepted
// while the last result is waiting. The running maximum is kept incrementally:
// totals only grow, so only the touched entry can displace the current best,
// and on a tie the smaller key stays. An add of a new key to a full table
// changes nothing and returns one result with full_error set.
// ----------------------------------------------------------------------------
`include "sorted_key_accumulate_table_macros.svh"

module sorted_key_accumulate_table #(
    parameter int TABLE_DEPTH = skat_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_mode,
    input  logic [skat_pkg::CODE_W-1:0]       s_client_code,
    input  logic [skat_pkg::AMT_W-1:0]        s_sale_amount,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_entry_valid,
    output logic [skat_pkg::CODE_W-1:0]       m_entry_code,
    output logic [skat_pkg::TOTAL_W-1:0]      m_entry_total,
    output logic                              m_full_error,
    output logic                              m_max_valid,
    output logic [skat_pkg::CODE_W-1:0]       m_max_code,
    output logic [skat_pkg::TOTAL_W-1:0]      m_max_total,
    output logic                              m_last
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);  // entry count
    localparam int IW = $clog2(TABLE_DEPTH);      // rotation step

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    skat_pkg::state_t                 state_reg, state_next;
    logic [CW-1:0]                    count_reg, count_next;
    logic [IW-1:0]                    rot_reg, rot_next;
    logic                             drop_reg, drop_next;
    logic                             empty_reg, empty_next;
    logic [skat_pkg::CODE_W-1:0]      best_code_reg, best_code_next;
    logic [skat_pkg::TOTAL_W-1:0]     best_total_reg, best_total_next;

    // request payload and touched total (no reset needed)
    logic [skat_pkg::CODE_W-1:0]      req_code_reg;
    logic [skat_pkg::AMT_W-1:0]       req_amount_reg;
    logic [skat_pkg::TOTAL_W-1:0]     touched_reg, touched_next;

    // result register
    logic                             m_valid_reg;
    logic                             m_entry_valid_reg;
    logic [skat_pkg::CODE_W-1:0]      m_entry_code_reg;
    logic [skat_pkg::TOTAL_W-1:0]     m_entry_total_reg;
    logic                             m_full_error_reg;
    logic                             m_max_valid_reg;
    logic [skat_pkg::CODE_W-1:0]      m_max_code_reg;
    logic [skat_pkg::TOTAL_W-1:0]     m_max_total_reg;
    logic                             m_last_reg;

    // ------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------
    skat_pkg::cell_ctrl_t             cell_ctrl;
    skat_pkg::cell_op_t               cell_op;
    logic [TABLE_DEPTH-1:0]           cell_valid;
    logic [TABLE_DEPTH-1:0]           cell_lt;
    logic [TABLE_DEPTH-1:0]           cell_eq;
    logic [skat_pkg::CODE_W-1:0]      cell_code  [TABLE_DEPTH];
    logic [skat_pkg::TOTAL_W-1:0]     cell_total [TABLE_DEPTH];
    logic [skat_pkg::TOTAL_W-1:0]     cell_sum   [TABLE_DEPTH];

    logic                             any_eq;
    logic                             table_full;
    logic                             upd_drop;
    logic [skat_pkg::TOTAL_W-1:0]     hit_total;

    assign any_eq     = |cell_eq;
    assign table_full = (count_reg == CW'(TABLE_DEPTH));
    assign upd_drop   = !any_eq && table_full;

    assign cell_ctrl.op     = cell_op;
    assign cell_ctrl.code   = req_code_reg;
    assign cell_ctrl.amount = req_amount_reg;
    assign cell_ctrl.any_eq = any_eq;
    assign cell_ctrl.drop   = upd_drop;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            logic                           p_lt;
            logic                           p_valid;
            logic [skat_pkg::CODE_W-1:0]    p_code;
            logic [skat_pkg::TOTAL_W-1:0]   p_total;
            localparam int NXT = (gi + 1) % TABLE_DEPTH;

            if (gi == 0) begin : g_head
                // cell 0 is always at or below the insertion point
                assign p_lt    = 1'b1;
                assign p_valid = 1'b0;
                assign p_code  = '0;
                assign p_total = '0;
            end else begin : g_body
                assign p_lt    = cell_lt[gi-1];
                assign p_valid = cell_valid[gi-1];
                assign p_code  = cell_code[gi-1];
                assign p_total = cell_total[gi-1];
            end

            skat_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (cell_ctrl),
                .prev_lt    (p_lt),
                .prev_valid (p_valid),
                .prev_code  (p_code),
                .prev_total (p_total),
                .next_valid (cell_valid[NXT]),
                .next_code  (cell_code[NXT]),
                .next_total (cell_total[NXT]),
                .valid      (cell_valid[gi]),
                .code       (cell_code[gi]),
                .total      (cell_total[gi]),
                .lt         (cell_lt[gi]),
                .eq         (cell_eq[gi]),
                .sum        (cell_sum[gi])
            );
        end
    endgenerate

    // at most one cell matches, so an OR of gated sums selects it
    always_comb begin
        hit_total = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            hit_total = hit_total | (cell_eq[i] ? cell_sum[i] : '0);
        end
    end

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    logic out_free;
    logic out_load;
    logic req_accept;
    logic dump_emit;
    logic dump_last;

    assign out_free   = !m_valid_reg || m_ready;
    assign req_accept = s_valid && s_ready;
    assign dump_emit  = (CW'(rot_reg) < count_reg);
    assign dump_last  = ((CW'(rot_reg) + CW'(1)) == count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= skat_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cell_op    = skat_pkg::CELL_HOLD;
        out_load   = 1'b0;
        case (state_reg)
            skat_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = s_mode ? skat_pkg::ST_DUMP : skat_pkg::ST_CMP;
                end
            end
            skat_pkg::ST_CMP: begin
                cell_op    = skat_pkg::CELL_CMP;
                state_next = skat_pkg::ST_UPD;
            end
            skat_pkg::ST_UPD: begin
                cell_op    = skat_pkg::CELL_UPD;
                state_next = skat_pkg::ST_FIN;
            end
            skat_pkg::ST_FIN: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = skat_pkg::ST_IDLE;
                end
            end
            skat_pkg::ST_DUMP: begin
                if (out_free) begin
                    if (count_reg == '0) begin
                        out_load   = 1'b1;
                        state_next = skat_pkg::ST_IDLE;
                    end else begin
                        cell_op  = skat_pkg::CELL_ROT;
                        out_load = dump_emit;
                        if (rot_reg == IW'(TABLE_DEPTH - 1)) begin
                            state_next = skat_pkg::ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = skat_pkg::ST_IDLE;
            end
        endcase
    end

    // counters, flags and running maximum
    always_comb begin
        count_next      = count_reg;
        rot_next        = rot_reg;
        drop_next       = drop_reg;
        empty_next      = empty_reg;
        touched_next    = touched_reg;
        best_code_next  = best_code_reg;
        best_total_next = best_total_reg;

        if (req_accept) begin
            rot_next = '0;
        end
        if (cell_op == skat_pkg::CELL_ROT) begin
            rot_next = rot_reg + IW'(1);
        end
        if (state_reg == skat_pkg::ST_UPD) begin
            drop_next    = upd_drop;
            empty_next   = (count_reg == '0);
            touched_next = any_eq ? hit_total
                                  : {{(skat_pkg::TOTAL_W-skat_pkg::AMT_W){1'b0}},
                                     req_amount_reg};
            if (!any_eq && !table_full) begin
                count_next = count_reg + CW'(1);
            end
        end
        // only the touched entry can overtake the best; ties keep the smaller key
        if (state_reg == skat_pkg::ST_FIN && !drop_reg) begin
            if (empty_reg || (touched_reg > best_total_reg) ||
                ((touched_reg == best_total_reg) && (req_code_reg < best_code_reg))) begin
                best_code_next  = req_code_reg;
                best_total_next = touched_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            rot_reg        <= '0;
            drop_reg       <= 1'b0;
            empty_reg      <= 1'b0;
            best_code_reg  <= '0;
            best_total_reg <= '0;
        end else begin
            count_reg <= count_next;
            rot_reg   <= rot_next;
            drop_reg  <= drop_next;
            empty_reg <= empty_next;
            if (out_load) begin
                best_code_reg  <= best_code_next;
                best_total_reg <= best_total_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req_accept) begin
            req_code_reg   <= s_client_code;
            req_amount_reg <= s_sale_amount;
        end
        touched_reg <= touched_next;
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (state_reg == skat_pkg::ST_FIN) begin
                // add result: touched entry or full-table drop
                m_entry_valid_reg <= !drop_reg;
                m_entry_code_reg  <= drop_reg ? '0 : req_code_reg;
                m_entry_total_reg <= drop_reg ? '0 : touched_reg;
                m_full_error_reg  <= drop_reg;
                m_max_valid_reg   <= (count_reg != '0);
                m_max_code_reg    <= best_code_next;
                m_max_total_reg   <= best_total_next;
                m_last_reg        <= 1'b1;
            end else if (count_reg == '0) begin
                // dump of an empty table
                m_entry_valid_reg <= 1'b0;
                m_entry_code_reg  <= '0;
                m_entry_total_reg <= '0;
                m_full_error_reg  <= 1'b0;
                m_max_valid_reg   <= 1'b0;
                m_max_code_reg    <= best_code_reg;
                m_max_total_reg   <= best_total_reg;
                m_last_reg        <= 1'b1;
            end else begin
                // dump step: cell 0 holds the next entry in key order
                m_entry_valid_reg <= 1'b1;
                m_entry_code_reg  <= cell_code[0];
                m_entry_total_reg <= cell_total[0];
                m_full_error_reg  <= 1'b0;
                m_max_valid_reg   <= 1'b1;
                m_max_code_reg    <= best_code_reg;
                m_max_total_reg   <= best_total_reg;
                m_last_reg        <= dump_last;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_entry_valid = m_entry_valid_reg;
    assign m_entry_code  = m_entry_code_reg;
    assign m_entry_total = m_entry_total_reg;
    assign m_full_error  = m_full_error_reg;
    assign m_max_valid   = m_max_valid_reg;
    assign m_max_code    = m_max_code_reg;
    assign m_max_total   = m_max_total_reg;
    assign m_last        = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SKAT_ASSERT_ALWAYS(a_count_range, aclk, aresetn, count_reg <= CW'(TABLE_DEPTH), "count over depth")

    `SKAT_ASSERT_IMPLY(a_cells_match_count, aclk, aresetn, state_reg == skat_pkg::ST_IDLE, $countones(cell_valid) == int'(count_reg), "occupied cells disagree with count")

    `SKAT_ASSERT_IMPLY(a_single_match, aclk, aresetn, state_reg == skat_pkg::ST_UPD, $onehot0(cell_eq), "more than one cell matched the key")

    `SKAT_ASSERT_NEXT(a_add_result, aclk, aresetn, (state_reg == skat_pkg::ST_FIN) && out_free, m_valid_reg && m_last_reg, "add result not loaded")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted key/total table.
// ----------------------------------------------------------------------------
// Drives add and dump requests through the valid/ready request channel. A
// table model in the scoreboard works out every result each accepted request
// should produce. Results are checked field by field and in order.
// Stimulus has three parts:
//   - a short directed list: empty dump, key and amount extremes, ties on the
//     maximum, inserts at the front, middle and end, and dumps
//   - about 400 random requests that fill the table and then keep hitting it
//   - closing dumps around one last add
// Both sides idle at random, and the result side once holds off long enough
// to back the block up into its request side.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int TABLE_DEPTH     = skat_pkg::DEFAULT_TABLE_DEPTH;
    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 9;
    localparam int RANDOM_REQUESTS = 400;
    localparam int CHUNK           = 40;     // idling is switched on or off per chunk
    localparam int HOLD_OFF_CYCLES = 400;    // long result-side hold-off
    localparam int STALL_LIMIT     = 4000;   // cycles with no handshake at all
    localparam int DRAIN_LIMIT     = 20000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int MAX_REPORTS     = 100;
    localparam int POOL_SIZE       = 48;

    typedef logic [skat_pkg::CODE_W-1:0]  code_t;
    typedef logic [skat_pkg::AMT_W-1:0]   amount_t;
    typedef logic [skat_pkg::TOTAL_W-1:0] total_t;

    localparam total_t  TOTAL_MAX  = '1;
    localparam amount_t AMOUNT_MAX = '1;

    typedef enum logic {
        MODE_ADD  = 1'b0,
        MODE_DUMP = 1'b1
    } req_mode_t;

    // Field order matches the concatenation used when sampling the ports.
    typedef struct packed {
        logic   entry_valid;
        code_t  entry_code;
        total_t entry_total;
        logic   full_error;
        logic   max_valid;
        code_t  max_code;
        total_t max_total;
        logic   last;
    } table_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: holds its own sorted copy of the table and a queue of the
    // results still owed by the block.
    // ------------------------------------------------------------------------
    class table_scoreboard;
        code_t              codes[TABLE_DEPTH];
        total_t             totals[TABLE_DEPTH];
        int unsigned        fill;
        code_t              best_code;
        total_t             best_total;
        table_result_t      owed[$];
        int unsigned        failures;
        int unsigned        reports;
        int unsigned        results_checked;
        int unsigned        adds;
        int unsigned        inserts;
        int unsigned        full_drops;
        int unsigned        dumps;

        function new();
            fill            = 0;
            best_code       = '0;
            best_total      = '0;
            failures        = 0;
            reports         = 0;
            results_checked = 0;
            adds            = 0;
            inserts         = 0;
            full_drops      = 0;
            dumps           = 0;
        endfunction

        // Max fields always reflect the table as it stands after the request.
        function table_result_t make_result(logic valid, code_t code, total_t total,
                                            logic full, logic last_mark);
            table_result_t r;
            r.entry_valid = valid;
            r.entry_code  = code;
            r.entry_total = total;
            r.full_error  = full;
            r.max_valid   = (fill != 0);
            r.max_code    = best_code;
            r.max_total   = best_total;
            r.last        = last_mark;
            return r;
        endfunction

        function void note_request(req_mode_t mode, code_t code, amount_t amount);
            int unsigned                  pos;
            total_t                       amount_ext;
            logic [skat_pkg::TOTAL_W:0]   sum;
            amount_ext = total_t'(amount);
            if (mode == MODE_DUMP) begin
                dumps++;
                if (fill == 0) begin
                    owed.push_back(make_result(1'b0, '0, '0, 1'b0, 1'b1));
                end else begin
                    for (int i = 0; i < fill; i++)
                        owed.push_back(make_result(1'b1, codes[i], totals[i], 1'b0,
                                                   i + 1 == fill));
                end
                return;
            end

            adds++;
            // first slot whose key is not below the request key
            pos = 0;
            while (pos < fill && codes[pos] < code)
                pos++;

            if (pos < fill && codes[pos] == code) begin
                sum = {1'b0, totals[pos]} + {1'b0, amount_ext};
                totals[pos] = sum[skat_pkg::TOTAL_W] ? TOTAL_MAX
                                                     : sum[skat_pkg::TOTAL_W-1:0];
            end else if (fill == TABLE_DEPTH) begin
                // dropped: table and maximum untouched
                full_drops++;
                owed.push_back(make_result(1'b0, '0, '0, 1'b1, 1'b1));
                return;
            end else begin
                for (int i = fill; i > pos; i--) begin
                    codes[i]  = codes[i-1];
                    totals[i] = totals[i-1];
                end
                codes[pos]  = code;
                totals[pos] = amount_ext;
                fill++;
                inserts++;
            end

            // ascending scan, strictly larger wins, so ties keep the smaller key
            best_code  = codes[0];
            best_total = totals[0];
            for (int i = 1; i < fill; i++) begin
                if (totals[i] > best_total) begin
                    best_code  = codes[i];
                    best_total = totals[i];
                end
            end
            owed.push_back(make_result(1'b1, codes[pos], totals[pos], 1'b0, 1'b1));
        endfunction

        function void check_field(string name, total_t want, total_t got);
            if (want !== got) begin
                failures++;
                if (reports < MAX_REPORTS)
                    $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                reports++;
            end
        endfunction

        function void check_result(table_result_t got);
            table_result_t want;
            if (owed.size() == 0) begin
                failures++;
                if (reports < MAX_REPORTS)
                    $error("result with nothing outstanding: code 0x%0h total 0x%0h",
                           got.entry_code, got.entry_total);
                reports++;
                return;
            end
            want = owed.pop_front();
            results_checked++;
            check_field("entry_valid", total_t'(want.entry_valid),
                        total_t'(got.entry_valid));
            check_field("entry_code", total_t'(want.entry_code), total_t'(got.entry_code));
            check_field("entry_total", want.entry_total, got.entry_total);
            check_field("full_error", total_t'(want.full_error), total_t'(got.full_error));
            check_field("max_valid", total_t'(want.max_valid), total_t'(got.max_valid));
            check_field("max_code", total_t'(want.max_code), total_t'(got.max_code));
            check_field("max_total", want.max_total, got.max_total);
            check_field("last", total_t'(want.last), total_t'(got.last));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT and shared state
    // ------------------------------------------------------------------------
    logic    aclk = 1'b0;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    logic    s_mode;
    code_t   s_client_code;
    amount_t s_sale_amount;
    logic    m_valid;
    logic    m_ready;
    logic    m_entry_valid;
    code_t   m_entry_code;
    total_t  m_entry_total;
    logic    m_full_error;
    logic    m_max_valid;
    code_t   m_max_code;
    total_t  m_max_total;
    logic    m_last;

    table_scoreboard sb;
    bit              idle_on       = 1'b1;   // random gaps on both sides
    bit              hold_off_req  = 1'b0;   // asks the result side for one long hold-off
    int              quiet_cycles  = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    sorted_key_accumulate_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_client_code (s_client_code),
        .s_sale_amount (s_sale_amount),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_entry_valid (m_entry_valid),
        .m_entry_code  (m_entry_code),
        .m_entry_total (m_entry_total),
        .m_full_error  (m_full_error),
        .m_max_valid   (m_max_valid),
        .m_max_code    (m_max_code),
        .m_max_total   (m_max_total),
        .m_last        (m_last)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 93)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    task automatic end_run(bit timed_out);
        if (!timed_out && sb.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    endtask

    // One request: optional gap, then hold valid and payload until accepted.
    // Called right after a rising edge, so every drive lands on an edge.
    task automatic send_request(req_mode_t mode, code_t code, amount_t amount);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 99) < 40)
            gap = pick_idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= mode;
        s_client_code <= code;
        s_sale_amount <= amount;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(mode, code, amount);
    endtask

    // ------------------------------------------------------------------------
    // Result side: checks on every handshake and picks the next ready value.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        table_result_t got;
        int            stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got = {m_entry_valid, m_entry_code, m_entry_total, m_full_error,
                       m_max_valid, m_max_code, m_max_total, m_last};
                sb.check_result(got);
            end
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_off_req) begin
                // long hold-off, counted here; the request side keeps offering
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 99) < 25) begin
                stall_left = pick_idle_len() - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any handshake means the block is stuck.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     quiet_cycles, sb.owed.size());
            end_run(1'b1);
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    initial begin : stimulus
        code_t       key_pool[POOL_SIZE];
        code_t       code;
        amount_t     amount;
        req_mode_t   mode;
        int unsigned pick;
        int unsigned waited;

        sb = new();
        s_valid       <= 1'b0;
        s_mode        <= MODE_ADD;
        s_client_code <= '0;
        s_sale_amount <= '0;
        aresetn       <= 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed ---
        send_request(MODE_DUMP, 16'h1234, 16'h5678);  // empty table: one blank result
        send_request(MODE_ADD, 16'h8000, 16'h0000);   // first entry, zero total
        send_request(MODE_ADD, 16'hFFFF, AMOUNT_MAX); // insert at the end, top key
        send_request(MODE_ADD, 16'h0000, AMOUNT_MAX); // insert at the front, ties max
        send_request(MODE_ADD, 16'h8000, AMOUNT_MAX); // accumulate: three-way tie
        send_request(MODE_ADD, 16'h4000, 16'h0001);   // insert in the middle
        send_request(MODE_DUMP, 16'hFFFF, 16'hFFFF);
        send_request(MODE_ADD, 16'hFFFF, 16'h0001);   // largest key takes the max
        send_request(MODE_ADD, 16'h0000, 16'h0001);   // tie again, smaller key wins
        send_request(MODE_ADD, 16'h5555, 16'hAAAA);
        send_request(MODE_ADD, 16'hAAAA, 16'h5555);
        send_request(MODE_ADD, 16'h4000, 16'h0000);   // accumulate zero
        send_request(MODE_DUMP, 16'h0000, 16'h0000);

        // --- random ---
        // A fixed pool of keys keeps revisiting entries while the table
        // fills; once full, new keys are dropped with full_error.
        foreach (key_pool[i])
            key_pool[i] = code_t'($urandom);
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % CHUNK == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if (n == CHUNK)
                hold_off_req = 1'b1;

            pick = $urandom_range(0, 99);
            if (pick < 30 && sb.fill != 0)
                code = sb.codes[$urandom_range(0, sb.fill - 1)];
            else if (pick < 70)
                code = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                code = code_t'($urandom);

            pick = $urandom_range(0, 99);
            if (pick < 10)
                amount = '0;
            else if (pick < 20)
                amount = AMOUNT_MAX;
            else
                amount = amount_t'($urandom);

            mode = ($urandom_range(0, 99) < 8) ? MODE_DUMP : MODE_ADD;
            send_request(mode, code, amount);
        end

        // --- closing ---
        send_request(MODE_DUMP, code_t'($urandom), amount_t'($urandom));
        send_request(MODE_ADD, code_t'($urandom), amount_t'($urandom));
        send_request(MODE_DUMP, code_t'($urandom), amount_t'($urandom));
        s_valid <= 1'b0;

        // --- drain ---
        waited = 0;
        while (sb.owed.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (sb.owed.size() != 0) begin
            $display("drain timeout: %0d results never arrived", sb.owed.size());
            end_run(1'b1);
        end else begin
            // any stray result in this window counts as a failure
            repeat (SETTLE_CYCLES) @(posedge aclk);
            $display("Run covered %0d adds (%0d new keys, %0d dropped on a full table)",
                     sb.adds, sb.inserts, sb.full_drops);
            $display("and %0d dumps; %0d results checked, %0d of %0d entries used.",
                     sb.dumps, sb.results_checked, sb.fill, TABLE_DEPTH);
            end_run(1'b0);
        end
    end

endmodule
